// ----- rtl/core/pka_pkg.sv -----
`timescale 1ns / 1ps

package pka_pkg;

   localparam int unsigned KMER_LEN_WIDTH = 6;
   localparam logic [KMER_LEN_WIDTH-1:0] KMER_LEN_RESET = 6'd23;

   // Operation codes carried in the mode field.
   localparam logic [2:0] MODE_NEXT    = 3'd0;
   localparam logic [2:0] MODE_PREV    = 3'd1;
   localparam logic [2:0] MODE_PLUS    = 3'd2;
   localparam logic [2:0] MODE_REVCOMP = 3'd3;
   localparam logic [2:0] MODE_COMPARE = 3'd4;
   localparam logic [2:0] MODE_AND     = 3'd5;
   localparam logic [2:0] MODE_ENDS    = 3'd6;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] kmer_a_high;
      logic [63:0] kmer_a_low;
      logic [63:0] kmer_b_high;
      logic [63:0] kmer_b_low;
      logic [1:0]  base_in;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
      logic [1:0]  first_base;
      logic [1:0]  last_base;
      logic        is_less;
      logic        is_greater;
      logic        is_equal;
   } rsp_type;

endpackage

// ----- rtl/core/pka_datapath.sv -----
`timescale 1ns / 1ps

// Combinational k-mer operations; sits between the request and result registers.
module pka_datapath (
   input  pka_pkg::req_type                        req,
   input  logic [pka_pkg::KMER_LEN_WIDTH-1:0]      kmer_len,
   output pka_pkg::rsp_type                        rsp
);
   import pka_pkg::*;

   // Complement every base and reverse the order of the 32 bases in a word.
   function automatic logic [63:0] rc_word(input logic [63:0] w);
      logic [63:0] x;
      x = w ^ 64'hAAAA_AAAA_AAAA_AAAA;
      x = ((x & 64'h3333_3333_3333_3333) << 2) | ((x & 64'hCCCC_CCCC_CCCC_CCCC) >> 2);
      x = ((x & 64'h0F0F_0F0F_0F0F_0F0F) << 4) | ((x & 64'hF0F0_F0F0_F0F0_F0F0) >> 4);
      x = ((x & 64'h00FF_00FF_00FF_00FF) << 8) | ((x & 64'hFF00_FF00_FF00_FF00) >> 8);
      x = ((x & 64'h0000_FFFF_0000_FFFF) << 16) | ((x & 64'hFFFF_0000_FFFF_0000) >> 16);
      x = {x[31:0], x[63:32]};
      return x;
   endfunction

   logic [127:0] kmer_a;
   logic [127:0] kmer_b;
   logic [127:0] shl2;
   logic [127:0] shr2;
   logic [127:0] len_mask;
   logic [127:0] first_pos_base;
   logic [127:0] rc_full;
   logic [127:0] rc_shifted;
   logic [127:0] a_at_first;
   logic [63:0]  rc_lo_word;
   logic [6:0]   two_k;
   logic [6:0]   first_pos;
   logic [6:0]   shift_long;
   logic [6:0]   shift_short;
   logic         len_zero;
   logic         len_short;
   logic [127:0] result;

   assign kmer_a      = {req.kmer_a_high, req.kmer_a_low};
   assign kmer_b      = {req.kmer_b_high, req.kmer_b_low};
   assign two_k       = {kmer_len, 1'b0};
   assign first_pos   = two_k - 7'd2;
   assign len_zero    = (kmer_len == '0);
   assign len_short   = (kmer_len < 6'd32);
   // 128 - 2k for long k-mers and 64 - 2k for short ones; both stay within 2..64.
   assign shift_long  = 7'd0 - two_k;
   assign shift_short = 7'd64 - two_k;

   assign shl2           = kmer_a << 2;
   assign shr2           = kmer_a >> 2;
   assign len_mask       = (128'd1 << two_k) - 128'd1;
   assign first_pos_base = {126'd0, req.base_in} << first_pos;
   assign a_at_first     = kmer_a >> first_pos;

   assign rc_lo_word = rc_word(req.kmer_a_low);
   assign rc_full    = {rc_lo_word, rc_word(req.kmer_a_high)};
   assign rc_shifted = rc_full >> shift_long;

   always_comb begin
      result = '0;
      rsp    = '0;
      case (req.mode)
         MODE_NEXT: begin
            result = (shl2 & len_mask) | {126'd0, req.base_in};
         end
         MODE_PREV: begin
            result = len_zero ? shr2 : (shr2 | first_pos_base);
         end
         MODE_PLUS: begin
            result = shl2 | {126'd0, req.base_in};
         end
         MODE_REVCOMP: begin
            if (len_short) begin
               result[127:64] = req.kmer_a_high;
               result[63:0]   = len_zero ? 64'd0 : (rc_lo_word >> shift_short);
            end else begin
               result = rc_shifted;
            end
         end
         MODE_COMPARE: begin
            rsp.is_equal   = (kmer_a == kmer_b);
            rsp.is_less    = (kmer_a < kmer_b);
            rsp.is_greater = (kmer_a > kmer_b);
         end
         MODE_AND: begin
            result = kmer_a & kmer_b;
         end
         MODE_ENDS: begin
            rsp.last_base  = req.kmer_a_low[1:0];
            rsp.first_base = len_zero ? 2'd0 : a_at_first[1:0];
         end
         default: begin
            result = '0;
         end
      endcase
      rsp.result_high = result[127:64];
      rsp.result_low  = result[63:0];
   end

endmodule

// ----- rtl/core/packed_kmer_alu.sv -----
`timescale 1ns / 1ps

// An accepted transaction is registered in req_ff; its result is registered in rsp_ff and
// shown with rsp_strobe. Throughput: one transaction per cycle; busy is low whenever reset is low.
// Reset: synchronous, active high; clears the pipeline valid flags and loads kmer_len
// with 23. The receiver cannot stall, so every result is delivered on its own cycle.
module packed_kmer_alu (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  pka_pkg::req_type                    req_data,
   output logic                                rsp_strobe,
   output pka_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pka_pkg::KMER_LEN_WIDTH-1:0]  csr_data
);
   import pka_pkg::*;

   // Stage one holds the accepted request, stage two holds the finished result.
   logic                       req_valid_ff;
   req_type                    req_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;
   rsp_type                    rsp_in;
   logic [KMER_LEN_WIDTH-1:0]  kmer_len_ff;
   logic                       accept;

   // The unit holds off new transactions only while busy; busy only covers the reset cycles,
   // during which the pipeline is being cleared.
   assign busy      = reset;
   assign accept    = start & ~busy;
   // csr_ready is tied high, but a write during reset is lost. Writes are only expected while the
   // pipeline is empty, so an in-flight transaction never sees a length change; the block does not enforce it.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kmer_len_ff  <= KMER_LEN_RESET;
      end else begin
         req_valid_ff <= accept;
         rsp_valid_ff <= req_valid_ff;
         if (csr_valid && csr_ready) begin
            kmer_len_ff <= csr_data;
         end
      end
   end

   // Payload registers carry no reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // All operations fit in one short combinational pass between the two registers.
   pka_datapath u_datapath (
      .req      (req_ff),
      .kmer_len (kmer_len_ff),
      .rsp      (rsp_in)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/core/pka_checker.sv -----
`timescale 1ns / 1ps

module pka_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  pka_pkg::req_type                    req_data,
   input  logic                                rsp_strobe,
   input  pka_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [pka_pkg::KMER_LEN_WIDTH-1:0]  csr_data
);
   import pka_pkg::*;

   // Every accepted transaction produces a result strobe.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted transaction produced no result");

   // No result appears without an earlier accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##2 !rsp_strobe)
      else $error("result strobe without an accepted transaction");

   // A compare transaction yields exactly one of the three flags.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_COMPARE)
         |-> ##2 $onehot({rsp_data.is_less, rsp_data.is_greater, rsp_data.is_equal}))
      else $error("compare flags are not exactly one-hot");

   // Outside reset the unit always takes new transactions.
   assert property (@(posedge clock) !reset |-> !busy)
      else $error("busy raised outside reset");

   // A length write is taken in the cycle it is offered and carries a known value.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> (csr_ready && !$isunknown(csr_data)))
      else $error("length write stalled or carried unknown data");

endmodule

bind packed_kmer_alu pka_checker u_pka_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_data   (csr_data)
);
